>>> hdl/wbp_pkg.sv
// Shared constants and types for the weighted Brovey pansharpening block.
// No dependencies; used by every module under hdl/.
package wbp_pkg;

    localparam int NUM_SPEC  = 4;   // spectral bands per pixel
    localparam int NUM_OUT   = 4;   // output bands per pixel
    localparam int SAMPLE_W  = 16;
    localparam int WEIGHT_W  = 16;
    localparam int PROD_W    = 33;  // signed weight x unsigned sample
    localparam int PSUM_W    = 35;  // signed sum of four products
    localparam int QBITS     = 16;  // quotient bits out of the divider
    localparam int NUM_W     = 46;  // 2*spec*pan*4096 + psum
    localparam int DEN_W     = 35;  // 2*psum
    localparam int REM_W     = 35;

    // Pipeline: 0 products, 1 psum, 2 dividend, 3 range check,
    // 4..19 one quotient bit each, 20 merge into output register.
    localparam int DIV_FIRST = 4;
    localparam int NS        = DIV_FIRST + QBITS + 1;

    localparam int PADDR_W   = 5;
    localparam int CNT_W     = 3;

    typedef enum logic [2:0] {
        REG_WEIGHT_0   = 3'd0,
        REG_WEIGHT_1   = 3'd1,
        REG_WEIGHT_2   = 3'd2,
        REG_WEIGHT_3   = 3'd3,
        REG_OUT_SELECT = 3'd4,
        REG_CLAMP_MAX  = 3'd5,
        REG_NODATA_EN  = 3'd6,
        REG_NODATA_VAL = 3'd7
    } t_reg_idx;

    // Per-pixel sideband traveling beside the lane data.
    typedef struct packed {
        logic last;
        logic miss;   // nodata sample seen or zero pseudo-pan sum
    } t_side;

endpackage

>>> hdl/wbp_psum.sv
// Pseudo-panchromatic sum: weighted products and their sum, plus nodata detection.
// Depends on wbp_pkg.
module wbp_psum (
    input  logic                                   i_clk,
    input  logic [wbp_pkg::NS-1:0]                 i_en,
    input  logic [wbp_pkg::WEIGHT_W-1:0]           i_weight [wbp_pkg::NUM_SPEC],
    input  logic [wbp_pkg::SAMPLE_W-1:0]           i_spec   [wbp_pkg::NUM_SPEC],
    input  logic [wbp_pkg::SAMPLE_W-1:0]           i_pan,
    input  logic [wbp_pkg::SAMPLE_W-1:0]           i_nodata,
    input  logic                                   i_last,
    output logic signed [wbp_pkg::PSUM_W-1:0]      o_psum,
    output wbp_pkg::t_side                         o_side
);

    logic signed [wbp_pkg::PROD_W-1:0] r_prod [wbp_pkg::NUM_SPEC];
    logic                              r_hit;
    logic                              r_last;
    logic signed [wbp_pkg::PSUM_W-1:0] r_psum;
    wbp_pkg::t_side                    r_side;
    logic signed [wbp_pkg::PSUM_W-1:0] n_psum;
    logic                              n_hit;

    always_comb begin
        n_hit = (i_pan == i_nodata);
        for (int i = 0; i < wbp_pkg::NUM_SPEC; i++) begin
            if (i_spec[i] == i_nodata) begin
                n_hit = 1'b1;
            end
        end
        n_psum = '0;
        for (int i = 0; i < wbp_pkg::NUM_SPEC; i++) begin
            n_psum = n_psum + wbp_pkg::PSUM_W'(r_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int i = 0; i < wbp_pkg::NUM_SPEC; i++) begin
                r_prod[i] <= $signed(i_weight[i]) * $signed({1'b0, i_spec[i]});
            end
            r_hit  <= n_hit;
            r_last <= i_last;
        end
        if (i_en[1]) begin
            r_psum      <= n_psum;
            r_side.last <= r_last;
            r_side.miss <= r_hit | (n_psum == '0);
        end
    end

    assign o_psum = r_psum;
    assign o_side = r_side;

endmodule

>>> hdl/wbp_lane.sv
// One output band: spectral x pan product and a radix-2 restoring divider,
// one quotient bit per stage. Depends on wbp_pkg.
module wbp_lane (
    input  logic                              i_clk,
    input  logic [wbp_pkg::NS-1:0]            i_en,
    input  logic [wbp_pkg::SAMPLE_W-1:0]      i_spec,
    input  logic [wbp_pkg::SAMPLE_W-1:0]      i_pan,
    input  logic signed [wbp_pkg::PSUM_W-1:0] i_psum,
    output logic [wbp_pkg::SAMPLE_W-1:0]      o_value
);

    logic [2*wbp_pkg::SAMPLE_W-1:0] r_sp_a;
    logic [2*wbp_pkg::SAMPLE_W-1:0] r_sp_b;
    logic [wbp_pkg::NUM_W-1:0]      r_num;
    logic [wbp_pkg::DEN_W-1:0]      r_den_c;
    logic                           r_pos_c;

    logic [wbp_pkg::REM_W-1:0]      r_rem [wbp_pkg::QBITS+1];
    logic [wbp_pkg::QBITS-1:0]      r_nlo [wbp_pkg::QBITS+1];
    logic [wbp_pkg::QBITS-1:0]      r_q   [wbp_pkg::QBITS+1];
    logic [wbp_pkg::DEN_W-1:0]      r_den [wbp_pkg::QBITS+1];
    logic                           r_sat [wbp_pkg::QBITS+1];
    logic                           r_pos [wbp_pkg::QBITS+1];

    logic [wbp_pkg::NUM_W-1:0]      n_num;
    logic [wbp_pkg::REM_W-1:0]      n_rem [wbp_pkg::QBITS];
    logic                           n_bit [wbp_pkg::QBITS];
    logic [wbp_pkg::REM_W:0]        n_try [wbp_pkg::QBITS];

    // Rounded quotient = floor((2*num + den) / (2*den)), num = sp*4096
    assign n_num = {1'b0, r_sp_b, 13'b0} + wbp_pkg::NUM_W'(i_psum[wbp_pkg::PSUM_W-2:0]);

    always_comb begin
        for (int j = 0; j < wbp_pkg::QBITS; j++) begin
            n_try[j] = {r_rem[j], r_nlo[j][wbp_pkg::QBITS-1]};
            n_bit[j] = (n_try[j] >= {1'b0, r_den[j]});
            n_rem[j] = n_bit[j] ? wbp_pkg::REM_W'(n_try[j] - {1'b0, r_den[j]})
                                : wbp_pkg::REM_W'(n_try[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sp_a <= i_spec * i_pan;
        end
        if (i_en[1]) begin
            r_sp_b <= r_sp_a;
        end
        if (i_en[2]) begin
            r_num   <= n_num;
            r_den_c <= {i_psum[wbp_pkg::DEN_W-2:0], 1'b0};
            r_pos_c <= !i_psum[wbp_pkg::PSUM_W-1] && (i_psum != '0);
        end
        if (i_en[3]) begin
            // Quotient needs more than 16 bits: saturate
            r_sat[0] <= (wbp_pkg::DEN_W'(r_num[wbp_pkg::NUM_W-1:wbp_pkg::QBITS]) >= r_den_c);
            r_rem[0] <= wbp_pkg::REM_W'(r_num[wbp_pkg::NUM_W-1:wbp_pkg::QBITS]);
            r_nlo[0] <= r_num[wbp_pkg::QBITS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= r_den_c;
            r_pos[0] <= r_pos_c;
        end
        for (int j = 0; j < wbp_pkg::QBITS; j++) begin
            if (i_en[wbp_pkg::DIV_FIRST+j]) begin
                r_rem[j+1] <= n_rem[j];
                r_nlo[j+1] <= {r_nlo[j][wbp_pkg::QBITS-2:0], 1'b0};
                r_q[j+1]   <= {r_q[j][wbp_pkg::QBITS-2:0], n_bit[j]};
                r_den[j+1] <= r_den[j];
                r_sat[j+1] <= r_sat[j];
                r_pos[j+1] <= r_pos[j];
            end
        end
    end

    assign o_value = !r_pos[wbp_pkg::QBITS] ? '0 :
                     r_sat[wbp_pkg::QBITS]  ? '1 : r_q[wbp_pkg::QBITS];

endmodule

>>> hdl/weighted_brovey_pansharpen.sv
// Top level of the weighted Brovey pansharpening block: config registers,
// pipeline flow control, four divider lanes and the merge stage.
// Depends on wbp_pkg, wbp_psum, wbp_lane.
// Usage:
//   Slave stream takes one pixel per transfer: tdata holds pan and four
//   spectral samples, tlast marks the last pixel of a region. Master stream
//   returns one result per pixel: four 16-bit bands in tdata, tlast copied.
//   APB port holds weights, band select, clamp and nodata settings; write
//   only while no pixel is in flight.
// Timing:
//   21 pipeline stages, the last one the output register. One pixel per
//   cycle sustained while the master side accepts results: the
//   lane dividers are fully pipelined, one quotient bit per stage.
// Flow control:
//   Each stage advances when it is empty or the next one advances, so
//   bubbles collapse and input is still taken while a result waits in the
//   output register. Input stalls only when every stage holds a pixel.
// Reset:
//   Synchronous active-low reset empties the pipeline and loads defaults:
//   weights 1.0, identity band select over four bands, clamp and nodata off.
module weighted_brovey_pansharpen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [79:0]                   i_s_tdata,  // pan_value, spectral_0..3
    input  logic                          i_s_tlast,  // last_pixel
    // result output
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [63:0]                   o_m_tdata,  // sharp_0..3
    output logic                          o_m_tlast,  // last_out
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LAST = wbp_pkg::NS - 1;

    // Configuration registers
    logic [wbp_pkg::WEIGHT_W-1:0] r_weight [wbp_pkg::NUM_SPEC];
    logic [10:0]                  r_out_sel;
    logic [15:0]                  r_clamp;
    logic                         r_nd_en;
    logic [15:0]                  r_nd_val;

    wbp_pkg::t_reg_idx            reg_idx;
    logic                         wr_en;

    assign pready  = 1'b1;
    assign reg_idx = wbp_pkg::t_reg_idx'(paddr[wbp_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wbp_pkg::NUM_SPEC; i++) begin
                r_weight[i] <= 16'd4096;
            end
            r_out_sel <= 11'd1252;
            r_clamp   <= '0;
            r_nd_en   <= 1'b0;
            r_nd_val  <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                wbp_pkg::REG_WEIGHT_0:   r_weight[0] <= pwdata[15:0];
                wbp_pkg::REG_WEIGHT_1:   r_weight[1] <= pwdata[15:0];
                wbp_pkg::REG_WEIGHT_2:   r_weight[2] <= pwdata[15:0];
                wbp_pkg::REG_WEIGHT_3:   r_weight[3] <= pwdata[15:0];
                wbp_pkg::REG_OUT_SELECT: r_out_sel   <= pwdata[10:0];
                wbp_pkg::REG_CLAMP_MAX:  r_clamp     <= pwdata[15:0];
                wbp_pkg::REG_NODATA_EN:  r_nd_en     <= pwdata[0];
                wbp_pkg::REG_NODATA_VAL: r_nd_val    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wbp_pkg::REG_WEIGHT_0:   prdata = {16'b0, r_weight[0]};
            wbp_pkg::REG_WEIGHT_1:   prdata = {16'b0, r_weight[1]};
            wbp_pkg::REG_WEIGHT_2:   prdata = {16'b0, r_weight[2]};
            wbp_pkg::REG_WEIGHT_3:   prdata = {16'b0, r_weight[3]};
            wbp_pkg::REG_OUT_SELECT: prdata = {21'b0, r_out_sel};
            wbp_pkg::REG_CLAMP_MAX:  prdata = {16'b0, r_clamp};
            wbp_pkg::REG_NODATA_EN:  prdata = {31'b0, r_nd_en};
            wbp_pkg::REG_NODATA_VAL: prdata = {16'b0, r_nd_val};
            default:                 prdata = '0;
        endcase
    end

    // Pipeline occupancy and per-stage advance
    logic [wbp_pkg::NS-1:0] r_v;
    logic [wbp_pkg::NS-1:0] stage_rdy;

    always_comb begin
        stage_rdy[LAST] = !r_v[LAST] || i_m_tready;
        for (int s = LAST - 1; s >= 0; s--) begin
            stage_rdy[s] = !r_v[s] || stage_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_rdy[0]) begin
                r_v[0] <= i_s_tvalid;
            end
            for (int s = 1; s < wbp_pkg::NS; s++) begin
                if (stage_rdy[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign o_s_tready = stage_rdy[0];

    // Input unpacking
    logic [15:0] pan;
    logic [15:0] spec [wbp_pkg::NUM_SPEC];

    assign pan = i_s_tdata[15:0];
    always_comb begin
        for (int i = 0; i < wbp_pkg::NUM_SPEC; i++) begin
            spec[i] = i_s_tdata[16*(i+1) +: 16];
        end
    end

    // Pseudo-pan sum
    logic signed [wbp_pkg::PSUM_W-1:0] psum;
    wbp_pkg::t_side                    side_b;

    wbp_psum u_psum (
        .i_clk    (i_clk),
        .i_en     (stage_rdy),
        .i_weight (r_weight),
        .i_spec   (spec),
        .i_pan    (pan),
        .i_nodata (r_nd_val),
        .i_last   (i_s_tlast),
        .o_psum   (psum),
        .o_side   (side_b)
    );

    // Lanes, each fed by its selected source band
    logic [15:0] lane_val [wbp_pkg::NUM_OUT];

    for (genvar k = 0; k < wbp_pkg::NUM_OUT; k++) begin : g_lane
        wbp_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (stage_rdy),
            .i_spec  (spec[r_out_sel[2*k +: 2]]),
            .i_pan   (pan),
            .i_psum  (psum),
            .o_value (lane_val[k])
        );
    end

    // Sideband alongside the dividend, range check and divider stages
    wbp_pkg::t_side r_side [2:LAST-1];

    always_ff @(posedge i_clk) begin
        if (stage_rdy[2]) begin
            r_side[2] <= side_b;
        end
        for (int s = 3; s < LAST; s++) begin
            if (stage_rdy[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // Merge: clamp, nodata substitution, unused bands to zero
    logic [wbp_pkg::CNT_W-1:0] band_cnt;
    logic [15:0]               n_band [wbp_pkg::NUM_OUT];
    logic [15:0]               v_clip;
    logic [15:0]               r_band [wbp_pkg::NUM_OUT];
    logic                      r_last;

    assign band_cnt = (r_out_sel[10:8] > wbp_pkg::CNT_W'(wbp_pkg::NUM_OUT)) ?
                      wbp_pkg::CNT_W'(wbp_pkg::NUM_OUT) : r_out_sel[10:8];

    always_comb begin
        v_clip = '0;
        for (int k = 0; k < wbp_pkg::NUM_OUT; k++) begin
            v_clip = lane_val[k];
            if (r_clamp != '0 && v_clip > r_clamp) begin
                v_clip = r_clamp;
            end
            if (r_nd_en && v_clip == r_nd_val) begin
                v_clip = (r_nd_val == '0) ? 16'd1 : r_nd_val - 16'd1;
            end
            if (wbp_pkg::CNT_W'(k) >= band_cnt) begin
                n_band[k] = '0;
            end else if (r_nd_en && r_side[LAST-1].miss) begin
                n_band[k] = r_nd_val;
            end else begin
                n_band[k] = v_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[LAST]) begin
            for (int k = 0; k < wbp_pkg::NUM_OUT; k++) begin
                r_band[k] <= n_band[k];
            end
            r_last <= r_side[LAST-1].last;
        end
    end

    assign o_m_tvalid = r_v[LAST];
    assign o_m_tlast  = r_last;
    always_comb begin
        for (int k = 0; k < wbp_pkg::NUM_OUT; k++) begin
            o_m_tdata[16*k +: 16] = r_band[k];
        end
    end

`ifndef ASSERT_OFF
    // Input is refused only when every stage holds a pixel
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_v))
        else $error("input stalled with a bubble in the pipeline");

    // No band count: all bands zero
    a_zero_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_sel[10:8] == '0) |-> (o_m_tdata == '0))
        else $error("unused bands not zero");

    // Clamp holds when nodata substitution is off
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_clamp != '0 && !r_nd_en) |->
        (o_m_tdata[15:0] <= r_clamp && o_m_tdata[31:16] <= r_clamp &&
         o_m_tdata[47:32] <= r_clamp && o_m_tdata[63:48] <= r_clamp))
        else $error("result above clamp");
`endif

endmodule
